/* sv/imp_pkg.sv */
// Package for the indexed max-priority table: command, status and state codes,
// field widths and the controller-to-datapath command and status structs.
// Depends on nothing.
`default_nettype none

package imp_pkg;

   localparam int CMD_BITS    = 3;
   localparam int STATUS_BITS = 3;
   localparam int ID_BITS     = 32;
   localparam int PRIO_BITS   = 31;
   localparam int RSP_PAY_BITS = 32;

   localparam logic [PRIO_BITS-1:0] PRIO_TOP = {PRIO_BITS{1'b1}};

   typedef enum logic [CMD_BITS-1:0] {
      CMD_ADD      = 3'd0,
      CMD_PROMOTE  = 3'd1,
      CMD_POP_MAX  = 3'd2,
      CMD_GET_MAX  = 3'd3,
      CMD_IS_VALID = 3'd4,
      CMD_GET      = 3'd5
   } cmd_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STAT_OK        = 3'd0,
      STAT_FULL      = 3'd1,
      STAT_NOT_FOUND = 3'd2,
      STAT_EMPTY     = 3'd3,
      STAT_EXHAUSTED = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      CTL_CLEAR,
      CTL_IDLE,
      CTL_SCAN,
      CTL_DRAIN,
      CTL_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic clear_wr;
      logic scan_rd;
      logic finish;
   } ctl_type;

   typedef struct packed {
      logic last_addr;
   } stat_type;

endpackage

`default_nettype wire

/* sv/imp_ctrl.sv */
// Controller for the indexed max-priority table: sequences the clearing pass,
// the slot scan and the closing update. Depends on imp_pkg.
`default_nettype none

module imp_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire imp_pkg::stat_type stat,
   output imp_pkg::ctl_type       ctl,
   output logic                   busy
);

   imp_pkg::state_type state_ff;
   imp_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= imp_pkg::CTL_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         imp_pkg::CTL_CLEAR: begin
            if (stat.last_addr) state_in = imp_pkg::CTL_IDLE;
         end
         imp_pkg::CTL_IDLE: begin
            if (start) state_in = imp_pkg::CTL_SCAN;
         end
         imp_pkg::CTL_SCAN: begin
            if (stat.last_addr) state_in = imp_pkg::CTL_DRAIN;
         end
         imp_pkg::CTL_DRAIN: begin
            state_in = imp_pkg::CTL_FINISH;
         end
         imp_pkg::CTL_FINISH: begin
            state_in = imp_pkg::CTL_IDLE;
         end
         default: begin
            state_in = imp_pkg::CTL_CLEAR;
         end
      endcase
   end

   always_comb begin
      ctl  = '0;
      busy = 1'b1;
      unique case (state_ff)
         imp_pkg::CTL_CLEAR: begin
            ctl.clear_wr = 1'b1;
         end
         imp_pkg::CTL_IDLE: begin
            busy     = 1'b0;
            ctl.load = start;
         end
         imp_pkg::CTL_SCAN: begin
            ctl.scan_rd = 1'b1;
         end
         imp_pkg::CTL_DRAIN: begin
         end
         imp_pkg::CTL_FINISH: begin
            ctl.finish = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // The scan must cover every slot before the table is updated.
   a_scan_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == imp_pkg::CTL_SCAN && !stat.last_addr) |=> state_ff == imp_pkg::CTL_SCAN)
      else $error("scan left before the last slot");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted command did not raise busy");

   a_finish_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.finish |=> (state_ff == imp_pkg::CTL_IDLE))
      else $error("update not followed by the idle state");

endmodule

`default_nettype wire

/* sv/imp_datapath.sv */
// Datapath for the indexed max-priority table: slot memory, scan counter,
// match and maximum search, id counter and result registers. Depends on imp_pkg.
`default_nettype none

module imp_datapath #(
   parameter int CAPACITY     = 16,
   parameter int PAYLOAD_BITS = 32
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire imp_pkg::ctl_type                   ctl,
   output imp_pkg::stat_type                       stat,
   input  wire logic [imp_pkg::CMD_BITS-1:0]       req_command,
   input  wire logic [imp_pkg::ID_BITS-1:0]        req_item_id,
   input  wire logic [imp_pkg::RSP_PAY_BITS-1:0]   req_payload,
   output logic                                    rsp_strobe,
   output logic [imp_pkg::STATUS_BITS-1:0]         rsp_status,
   output logic [imp_pkg::ID_BITS-1:0]             rsp_result_id,
   output logic [imp_pkg::RSP_PAY_BITS-1:0]        rsp_result_payload,
   output logic [imp_pkg::PRIO_BITS-1:0]           rsp_result_priority,
   output logic                                    rsp_is_member
);

   localparam int IW = $clog2(CAPACITY);
   localparam int PW = (PAYLOAD_BITS < imp_pkg::RSP_PAY_BITS) ? PAYLOAD_BITS
                                                              : imp_pkg::RSP_PAY_BITS;
   localparam int RW = 1 + imp_pkg::ID_BITS + imp_pkg::PRIO_BITS + PW;

   logic [RW-1:0] slot_mem [CAPACITY];

   logic [IW-1:0]                     addr_ff;
   logic [IW-1:0]                     addr_in;
   logic                              rd_valid_ff;
   logic [IW-1:0]                     rd_idx_ff;
   logic [RW-1:0]                     rd_row_ff;

   logic [imp_pkg::CMD_BITS-1:0]      cmd_ff;
   logic [imp_pkg::ID_BITS-1:0]       id_ff;
   logic [PW-1:0]                     pay_ff;

   logic                              hit_ff;
   logic [IW-1:0]                     hit_idx_ff;
   logic [imp_pkg::ID_BITS-1:0]       hit_id_ff;
   logic [imp_pkg::PRIO_BITS-1:0]     hit_prio_ff;
   logic [PW-1:0]                     hit_pay_ff;

   logic [imp_pkg::ID_BITS:0]         next_id_ff;
   logic [imp_pkg::ID_BITS:0]         next_id_in;

   logic                              rsp_strobe_ff;
   logic [imp_pkg::STATUS_BITS-1:0]   rsp_status_ff;
   logic [imp_pkg::ID_BITS-1:0]       rsp_id_ff;
   logic [imp_pkg::RSP_PAY_BITS-1:0]  rsp_pay_ff;
   logic [imp_pkg::PRIO_BITS-1:0]     rsp_prio_ff;
   logic                              rsp_member_ff;

   logic                              row_valid;
   logic [imp_pkg::ID_BITS-1:0]       row_id;
   logic [imp_pkg::PRIO_BITS-1:0]     row_prio;
   logic [PW-1:0]                     row_pay;
   logic                              take;

   logic                              wr_en;
   logic [IW-1:0]                     wr_addr;
   logic [RW-1:0]                     wr_row;
   logic                              fin_wr;
   logic [RW-1:0]                     fin_row;
   imp_pkg::status_type               fin_status;
   logic [imp_pkg::ID_BITS-1:0]       fin_id;
   logic [imp_pkg::RSP_PAY_BITS-1:0]  fin_pay;
   logic [imp_pkg::PRIO_BITS-1:0]     fin_prio;
   logic                              fin_member;
   logic                              fin_bump;
   logic [imp_pkg::PRIO_BITS-1:0]     new_prio;

   assign stat.last_addr = (addr_ff == IW'(CAPACITY - 1));

   always_comb begin
      addr_in = addr_ff;
      if (ctl.load) begin
         addr_in = '0;
      end else if (ctl.clear_wr || ctl.scan_rd) begin
         addr_in = stat.last_addr ? '0 : addr_ff + IW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff     <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         addr_ff     <= addr_in;
         rd_valid_ff <= ctl.scan_rd;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_row;
      end
      if (ctl.scan_rd) begin
         rd_row_ff <= slot_mem[addr_ff];
         rd_idx_ff <= addr_ff;
      end
   end

   assign row_valid = rd_row_ff[RW-1];
   assign row_id    = rd_row_ff[RW-2 -: imp_pkg::ID_BITS];
   assign row_prio  = rd_row_ff[PW +: imp_pkg::PRIO_BITS];
   assign row_pay   = rd_row_ff[PW-1:0];

   always_comb begin
      take = 1'b0;
      unique case (cmd_ff)
         imp_pkg::CMD_ADD: begin
            take = !row_valid && !hit_ff;
         end
         imp_pkg::CMD_PROMOTE, imp_pkg::CMD_IS_VALID, imp_pkg::CMD_GET: begin
            take = row_valid && (row_id == id_ff) && !hit_ff;
         end
         imp_pkg::CMD_POP_MAX, imp_pkg::CMD_GET_MAX: begin
            take = row_valid && (!hit_ff || (row_prio > hit_prio_ff) ||
                   ((row_prio == hit_prio_ff) && (row_id > hit_id_ff)));
         end
         default: begin
            take = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else if (ctl.load) begin
         hit_ff <= 1'b0;
      end else if (rd_valid_ff && take) begin
         hit_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff <= req_command;
         id_ff  <= req_item_id;
         pay_ff <= req_payload[PW-1:0];
      end
      if (rd_valid_ff && take) begin
         hit_idx_ff  <= rd_idx_ff;
         hit_id_ff   <= row_id;
         hit_prio_ff <= row_prio;
         hit_pay_ff  <= row_pay;
      end
   end

   assign new_prio = (hit_prio_ff == imp_pkg::PRIO_TOP) ? hit_prio_ff
                                                        : hit_prio_ff + imp_pkg::PRIO_BITS'(1);

   always_comb begin
      fin_wr     = 1'b0;
      fin_row    = {1'b1, hit_id_ff, hit_prio_ff, hit_pay_ff};
      fin_status = imp_pkg::STAT_OK;
      fin_id     = '0;
      fin_pay    = '0;
      fin_prio   = '0;
      fin_member = 1'b0;
      fin_bump   = 1'b0;
      unique case (cmd_ff)
         imp_pkg::CMD_ADD: begin
            if (next_id_ff[imp_pkg::ID_BITS]) begin
               fin_status = imp_pkg::STAT_EXHAUSTED;
            end else if (!hit_ff) begin
               fin_status = imp_pkg::STAT_FULL;
            end else begin
               fin_wr   = 1'b1;
               fin_row  = {1'b1, next_id_ff[imp_pkg::ID_BITS-1:0],
                           {imp_pkg::PRIO_BITS{1'b0}}, pay_ff};
               fin_id   = next_id_ff[imp_pkg::ID_BITS-1:0];
               fin_bump = 1'b1;
            end
         end
         imp_pkg::CMD_PROMOTE: begin
            fin_id = id_ff;
            if (!hit_ff) begin
               fin_status = imp_pkg::STAT_NOT_FOUND;
            end else begin
               fin_wr     = 1'b1;
               fin_row    = {1'b1, hit_id_ff, new_prio, hit_pay_ff};
               fin_prio   = new_prio;
               fin_member = 1'b1;
            end
         end
         imp_pkg::CMD_POP_MAX, imp_pkg::CMD_GET_MAX: begin
            if (!hit_ff) begin
               fin_status = imp_pkg::STAT_EMPTY;
            end else begin
               fin_id     = hit_id_ff;
               fin_pay    = imp_pkg::RSP_PAY_BITS'(hit_pay_ff);
               fin_prio   = hit_prio_ff;
               fin_member = 1'b1;
               if (cmd_ff == imp_pkg::CMD_POP_MAX) begin
                  fin_wr  = 1'b1;
                  fin_row = {1'b0, hit_id_ff, hit_prio_ff, hit_pay_ff};
               end
            end
         end
         imp_pkg::CMD_IS_VALID: begin
            fin_id     = id_ff;
            fin_member = hit_ff;
         end
         imp_pkg::CMD_GET: begin
            fin_id = id_ff;
            if (!hit_ff) begin
               fin_status = imp_pkg::STAT_NOT_FOUND;
            end else begin
               fin_pay    = imp_pkg::RSP_PAY_BITS'(hit_pay_ff);
               fin_member = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = addr_ff;
      wr_row  = '0;
      priority if (ctl.clear_wr) begin
         wr_en = 1'b1;
      end else if (ctl.finish) begin
         wr_en   = fin_wr;
         wr_addr = hit_idx_ff;
         wr_row  = fin_row;
      end
   end

   assign next_id_in = (ctl.finish && fin_bump) ? next_id_ff + (imp_pkg::ID_BITS + 1)'(1)
                                                : next_id_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         next_id_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         next_id_ff    <= next_id_in;
         rsp_strobe_ff <= ctl.finish;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.finish) begin
         rsp_status_ff <= fin_status;
         rsp_id_ff     <= fin_id;
         rsp_pay_ff    <= fin_pay;
         rsp_prio_ff   <= fin_prio;
         rsp_member_ff <= fin_member;
      end
   end

   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_result_id       = rsp_id_ff;
   assign rsp_result_payload  = rsp_pay_ff;
   assign rsp_result_priority = rsp_prio_ff;
   assign rsp_is_member       = rsp_member_ff;

   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> !$past(rsp_strobe_ff))
      else $error("two result beats in a row");

   a_scan_drained: assert property (@(posedge clock) disable iff (reset)
      ctl.finish |-> (!rd_valid_ff && !ctl.scan_rd))
      else $error("update issued before the scan finished");

   a_id_limit: assert property (@(posedge clock) disable iff (reset)
      next_id_ff[imp_pkg::ID_BITS] |-> (next_id_ff[imp_pkg::ID_BITS-1:0] == '0))
      else $error("id counter ran past its limit");

endmodule

`default_nettype wire

/* sv/indexed_max_priority_table.sv */
// Indexed max-priority table. A command is taken when start is high and busy low;
// its result beat appears after the scan, drain and update states, with rsp_strobe high.
// Busy holds off a new command until the last one is done: each command scans all slots
// through the single read port of the slot memory, then writes back at most once.
// After reset a clearing pass over all slots holds busy high.
`default_nettype none

module indexed_max_priority_table #(
   parameter int CAPACITY     = 16,
   parameter int PAYLOAD_BITS = 32
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic [imp_pkg::CMD_BITS-1:0]       req_command,
   input  wire logic [imp_pkg::ID_BITS-1:0]        req_item_id,
   input  wire logic [imp_pkg::RSP_PAY_BITS-1:0]   req_payload,
   output logic                                    rsp_strobe,
   output logic [imp_pkg::STATUS_BITS-1:0]         rsp_status,
   output logic [imp_pkg::ID_BITS-1:0]             rsp_result_id,
   output logic [imp_pkg::RSP_PAY_BITS-1:0]        rsp_result_payload,
   output logic [imp_pkg::PRIO_BITS-1:0]           rsp_result_priority,
   output logic                                    rsp_is_member
);

   imp_pkg::ctl_type  ctl;
   imp_pkg::stat_type stat;

   imp_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .ctl   (ctl),
      .busy  (busy)
   );

   imp_datapath #(
      .CAPACITY     (CAPACITY),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .ctl                 (ctl),
      .stat                (stat),
      .req_command         (req_command),
      .req_item_id         (req_item_id),
      .req_payload         (req_payload),
      .rsp_strobe          (rsp_strobe),
      .rsp_status          (rsp_status),
      .rsp_result_id       (rsp_result_id),
      .rsp_result_payload  (rsp_result_payload),
      .rsp_result_priority (rsp_result_priority),
      .rsp_is_member       (rsp_is_member)
   );

endmodule

`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for indexed_max_priority_table: a queue of commands feeds a
// clocked driver, and a clocked monitor checks every reply against a predicted slot table.
// Depends on imp_pkg and the indexed_max_priority_table RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY       = 16;
   localparam int PAYLOAD_BITS   = 32;
   localparam int RANDOM_CMDS    = 1420;
   localparam int LONG_GAP_MAX   = 120;
   localparam int WATCHDOG_LIMIT = 2000;

   localparam logic [imp_pkg::CMD_BITS-1:0]     CMD_SPARE_A = 3'd6;
   localparam logic [imp_pkg::CMD_BITS-1:0]     CMD_SPARE_B = 3'd7;
   localparam logic [imp_pkg::ID_BITS:0]        ID_LIMIT    = {1'b1, {imp_pkg::ID_BITS{1'b0}}};
   localparam logic [imp_pkg::RSP_PAY_BITS-1:0] PAY_MASK    =
      (PAYLOAD_BITS >= imp_pkg::RSP_PAY_BITS) ? {imp_pkg::RSP_PAY_BITS{1'b1}} :
      ({imp_pkg::RSP_PAY_BITS{1'b1}} >> (imp_pkg::RSP_PAY_BITS - PAYLOAD_BITS));

   typedef struct {
      logic [imp_pkg::CMD_BITS-1:0]     command;
      logic [imp_pkg::ID_BITS-1:0]      item_id;
      logic [imp_pkg::RSP_PAY_BITS-1:0] payload;
      int unsigned                      gap_after;
      bit                               hold_for_drain;
   } table_cmd_type;

   typedef struct {
      imp_pkg::status_type              status;
      logic [imp_pkg::ID_BITS-1:0]      result_id;
      logic [imp_pkg::RSP_PAY_BITS-1:0] result_payload;
      logic [imp_pkg::PRIO_BITS-1:0]    result_prio;
      logic                             is_member;
   } table_reply_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             start = 1'b0;
   logic                             busy;
   logic [imp_pkg::CMD_BITS-1:0]     req_command = '0;
   logic [imp_pkg::ID_BITS-1:0]      req_item_id = '0;
   logic [imp_pkg::RSP_PAY_BITS-1:0] req_payload = '0;
   logic                             rsp_strobe;
   logic [imp_pkg::STATUS_BITS-1:0]  rsp_status;
   logic [imp_pkg::ID_BITS-1:0]      rsp_result_id;
   logic [imp_pkg::RSP_PAY_BITS-1:0] rsp_result_payload;
   logic [imp_pkg::PRIO_BITS-1:0]    rsp_result_priority;
   logic                             rsp_is_member;

   table_cmd_type   pending_cmds[$];
   table_reply_type expected_replies[$];

   bit                               entry_valid[CAPACITY];
   logic [imp_pkg::ID_BITS-1:0]      entry_id[CAPACITY];
   logic [imp_pkg::RSP_PAY_BITS-1:0] entry_payload[CAPACITY];
   logic [imp_pkg::PRIO_BITS-1:0]    entry_prio[CAPACITY];
   logic [imp_pkg::ID_BITS:0]        id_counter = '0;

   bit          beat_taken = 1'b0;
   int unsigned gap_left = 0;
   int unsigned quiet_cycles = 0;
   int unsigned cmds_total = 0;
   int unsigned cmds_accepted = 0;
   int unsigned fail_count = 0;
   int unsigned cmd_tally[8];
   int unsigned status_tally[8];

   indexed_max_priority_table #(
      .CAPACITY(CAPACITY),
      .PAYLOAD_BITS(PAYLOAD_BITS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_command(req_command),
      .req_item_id(req_item_id),
      .req_payload(req_payload),
      .rsp_strobe(rsp_strobe),
      .rsp_status(rsp_status),
      .rsp_result_id(rsp_result_id),
      .rsp_result_payload(rsp_result_payload),
      .rsp_result_priority(rsp_result_priority),
      .rsp_is_member(rsp_is_member)
   );

   always #1 clock = ~clock;

   function automatic int slot_of(input logic [imp_pkg::ID_BITS-1:0] item_id);
      for (int i = 0; i < CAPACITY; i++)
         if (entry_valid[i] && entry_id[i] == item_id) return i;
      return -1;
   endfunction

   function automatic table_reply_type predict_reply(
         input logic [imp_pkg::CMD_BITS-1:0] command,
         input logic [imp_pkg::ID_BITS-1:0] item_id,
         input logic [imp_pkg::RSP_PAY_BITS-1:0] payload);
      table_reply_type r;
      int hit;
      r.status = imp_pkg::STAT_OK;
      r.result_id = '0;
      r.result_payload = '0;
      r.result_prio = '0;
      r.is_member = 1'b0;
      hit = -1;
      case (command)
         imp_pkg::CMD_ADD: begin
            if (id_counter >= ID_LIMIT) begin
               r.status = imp_pkg::STAT_EXHAUSTED;
            end else begin
               for (int i = CAPACITY - 1; i >= 0; i--)
                  if (!entry_valid[i]) hit = i;
               if (hit < 0) begin
                  r.status = imp_pkg::STAT_FULL;
               end else begin
                  entry_valid[hit] = 1'b1;
                  entry_id[hit] = id_counter[imp_pkg::ID_BITS-1:0];
                  entry_payload[hit] = payload & PAY_MASK;
                  entry_prio[hit] = '0;
                  r.result_id = id_counter[imp_pkg::ID_BITS-1:0];
                  id_counter = id_counter + (imp_pkg::ID_BITS + 1)'(1);
               end
            end
         end
         imp_pkg::CMD_PROMOTE: begin
            r.result_id = item_id;
            hit = slot_of(item_id);
            if (hit < 0) begin
               r.status = imp_pkg::STAT_NOT_FOUND;
            end else begin
               if (entry_prio[hit] != imp_pkg::PRIO_TOP)
                  entry_prio[hit] = entry_prio[hit] + imp_pkg::PRIO_BITS'(1);
               r.result_prio = entry_prio[hit];
               r.is_member = 1'b1;
            end
         end
         imp_pkg::CMD_POP_MAX, imp_pkg::CMD_GET_MAX: begin
            for (int i = 0; i < CAPACITY; i++)
               if (entry_valid[i] && (hit < 0 || entry_prio[i] > entry_prio[hit] ||
                     (entry_prio[i] == entry_prio[hit] && entry_id[i] > entry_id[hit])))
                  hit = i;
            if (hit < 0) begin
               r.status = imp_pkg::STAT_EMPTY;
            end else begin
               r.result_id = entry_id[hit];
               r.result_payload = entry_payload[hit];
               r.result_prio = entry_prio[hit];
               r.is_member = 1'b1;
               if (command == imp_pkg::CMD_POP_MAX) entry_valid[hit] = 1'b0;
            end
         end
         imp_pkg::CMD_IS_VALID: begin
            r.result_id = item_id;
            r.is_member = (slot_of(item_id) >= 0);
         end
         imp_pkg::CMD_GET: begin
            r.result_id = item_id;
            hit = slot_of(item_id);
            if (hit < 0) begin
               r.status = imp_pkg::STAT_NOT_FOUND;
            end else begin
               r.result_payload = entry_payload[hit];
               r.is_member = 1'b1;
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
         input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endtask

   function automatic int unsigned pick_gap(input bit calm);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 50) return 0;
      if (roll < 88) return $urandom_range(1, CAPACITY + 8);
      return $urandom_range(CAPACITY + 9, LONG_GAP_MAX);
   endfunction

   task automatic queue_cmd(input logic [imp_pkg::CMD_BITS-1:0] command,
         input logic [imp_pkg::ID_BITS-1:0] item_id,
         input logic [imp_pkg::RSP_PAY_BITS-1:0] payload, input int unsigned gap,
         input bit hold);
      table_cmd_type c;
      c.command = command;
      c.item_id = item_id;
      c.payload = payload;
      c.gap_after = gap;
      c.hold_for_drain = hold;
      pending_cmds.push_back(c);
      cmds_total++;
   endtask

   // Driver: a new beat is offered only after the previous one was taken and its gap has run out.
   always @(negedge clock) begin : drive
      table_cmd_type head;
      logic next_start;
      next_start = start;
      if (reset) begin
         next_start = 1'b0;
      end else if (!start || beat_taken) begin
         next_start = 1'b0;
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
         end else if (pending_cmds.size() > 0 &&
               !(pending_cmds[0].hold_for_drain && expected_replies.size() > 0)) begin
            head = pending_cmds.pop_front();
            req_command <= head.command;
            req_item_id <= head.item_id;
            req_payload <= head.payload;
            gap_left <= head.gap_after;
            next_start = 1'b1;
         end
      end
      start <= next_start;
   end

   always @(posedge clock) begin : observe
      table_reply_type want;
      beat_taken <= !reset && start && !busy;
      if (!reset && rsp_strobe === 1'b1) begin
         if (expected_replies.size() == 0) begin
            $error("reply beat arrived with no command outstanding");
            fail_count++;
         end else begin
            want = expected_replies.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_status));
            check_field("result_id", want.result_id, rsp_result_id);
            check_field("result_payload", want.result_payload, rsp_result_payload);
            check_field("result_priority", 32'(want.result_prio), 32'(rsp_result_priority));
            check_field("is_member", 32'(want.is_member), 32'(rsp_is_member));
         end
      end
      if (!reset && start && !busy) begin
         want = predict_reply(req_command, req_item_id, req_payload);
         expected_replies.push_back(want);
         cmds_accepted++;
         cmd_tally[req_command]++;
         status_tally[want.status]++;
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (start && !busy) || rsp_strobe === 1'b1) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $error("no beat in either direction for %0d cycles", quiet_cycles);
         $display("FAILED: results differ");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int unsigned adds_issued;
      int unsigned roll;
      int unsigned back;
      bit filling;
      bit calm;
      logic [imp_pkg::CMD_BITS-1:0] command;
      logic [imp_pkg::ID_BITS-1:0] item_id;

      for (int i = 0; i < CAPACITY; i++) entry_valid[i] = 1'b0;
      for (int i = 0; i < 8; i++) begin
         cmd_tally[i] = 0;
         status_tally[i] = 0;
      end

      // Empty table, unknown ids, unassigned codes, then a fill past capacity, queries and pops.
      queue_cmd(imp_pkg::CMD_POP_MAX, '0, '0, 0, 1'b0);
      queue_cmd(imp_pkg::CMD_GET_MAX, '1, '1, 0, 1'b0);
      queue_cmd(imp_pkg::CMD_PROMOTE, '0, '0, 0, 1'b0);
      queue_cmd(imp_pkg::CMD_GET, '1, '0, 0, 1'b0);
      queue_cmd(imp_pkg::CMD_IS_VALID, '1, '1, 0, 1'b0);
      queue_cmd(CMD_SPARE_A, '1, '1, 0, 1'b0);
      queue_cmd(CMD_SPARE_B, '1, '1, 0, 1'b0);
      queue_cmd(imp_pkg::CMD_ADD, '1, '0, 0, 1'b0);
      queue_cmd(imp_pkg::CMD_ADD, '0, '1, 0, 1'b0);
      for (int i = 2; i < CAPACITY; i++) queue_cmd(imp_pkg::CMD_ADD, '0, $urandom, 0, 1'b0);
      queue_cmd(imp_pkg::CMD_ADD, '0, $urandom, 0, 1'b0);
      queue_cmd(imp_pkg::CMD_PROMOTE, 32'd1, '0, 0, 1'b0);
      queue_cmd(imp_pkg::CMD_GET_MAX, '0, '0, 0, 1'b0);
      queue_cmd(imp_pkg::CMD_IS_VALID, 32'd1, '0, 0, 1'b0);
      queue_cmd(imp_pkg::CMD_GET, 32'd1, '0, 0, 1'b0);
      queue_cmd(imp_pkg::CMD_POP_MAX, '0, '0, 0, 1'b0);
      queue_cmd(imp_pkg::CMD_POP_MAX, '0, '0, 0, 1'b0);
      queue_cmd(imp_pkg::CMD_ADD, '0, $urandom, 0, 1'b0);
      adds_issued = CAPACITY + 2;

      // Random part: phases that lean towards filling or draining the table.
      filling = 1'b1;
      calm = 1'b0;
      for (int n = 0; n < RANDOM_CMDS; n++) begin
         if (n % 120 == 0) begin
            filling = $urandom_range(0, 1);
            calm = ($urandom_range(0, 3) == 0);
         end
         roll = $urandom_range(0, 99);
         if (filling) begin
            if (roll < 35) command = imp_pkg::CMD_ADD;
            else if (roll < 65) command = imp_pkg::CMD_PROMOTE;
            else if (roll < 73) command = imp_pkg::CMD_POP_MAX;
            else if (roll < 81) command = imp_pkg::CMD_GET_MAX;
            else if (roll < 89) command = imp_pkg::CMD_IS_VALID;
            else if (roll < 97) command = imp_pkg::CMD_GET;
            else command = roll[0] ? CMD_SPARE_A : CMD_SPARE_B;
         end else begin
            if (roll < 12) command = imp_pkg::CMD_ADD;
            else if (roll < 40) command = imp_pkg::CMD_PROMOTE;
            else if (roll < 70) command = imp_pkg::CMD_POP_MAX;
            else if (roll < 80) command = imp_pkg::CMD_GET_MAX;
            else if (roll < 88) command = imp_pkg::CMD_IS_VALID;
            else if (roll < 97) command = imp_pkg::CMD_GET;
            else command = roll[0] ? CMD_SPARE_A : CMD_SPARE_B;
         end
         roll = $urandom_range(0, 9);
         if (roll == 0) begin
            item_id = $urandom;
         end else if (roll == 1) begin
            item_id = adds_issued + $urandom_range(0, 3);
         end else begin
            back = $urandom_range(1, 2 * CAPACITY);
            item_id = (back > adds_issued) ? '0 : adds_issued - back;
         end
         if (command == imp_pkg::CMD_ADD) adds_issued++;
         queue_cmd(command, item_id, $urandom, pick_gap(calm), (n % 250 == 0));
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (cmds_accepted != cmds_total || expected_replies.size() != 0) @(negedge clock);
      repeat (CAPACITY + 5) @(posedge clock);

      $display("Commands run: %0d add, %0d promote, %0d pop max, %0d get max,",
         cmd_tally[imp_pkg::CMD_ADD], cmd_tally[imp_pkg::CMD_PROMOTE],
         cmd_tally[imp_pkg::CMD_POP_MAX], cmd_tally[imp_pkg::CMD_GET_MAX]);
      $display("   %0d is valid, %0d get, %0d unassigned.",
         cmd_tally[imp_pkg::CMD_IS_VALID], cmd_tally[imp_pkg::CMD_GET],
         cmd_tally[CMD_SPARE_A] + cmd_tally[CMD_SPARE_B]);
      $display("Replies: %0d ok, %0d table full, %0d unknown id, %0d table empty; %0d mismatches.",
         status_tally[imp_pkg::STAT_OK], status_tally[imp_pkg::STAT_FULL],
         status_tally[imp_pkg::STAT_NOT_FOUND], status_tally[imp_pkg::STAT_EMPTY],
         fail_count);
      if (fail_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

/* filelist.f */
sv/imp_pkg.sv
sv/imp_ctrl.sv
sv/imp_datapath.sv
sv/indexed_max_priority_table.sv
tb/testbench.sv
